/* rtl/core/sd_spi_block_read_receiver_macros.svh */
// Assertion macros shared by the SD SPI block read receiver modules.
`ifndef SD_SPI_BLOCK_READ_RECEIVER_MACROS_SVH
`define SD_SPI_BLOCK_READ_RECEIVER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SDRD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SDRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/sdrd_pkg.sv */
// Types, constants and the CRC-16 byte update for the SD SPI block read receiver.
package sdrd_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int R1_RETRIES  = 8;
  localparam int IDX_W       = $clog2(BLOCK_BYTES);

  localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
  localparam logic [7:0]  DATA_TOKEN = 8'hFE;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam int          CFG_IDX_W         = 1;
  localparam logic [0:0]  CFG_BLOCK_COUNT   = 1'b0;
  localparam logic [0:0]  CFG_TOKEN_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_DONE      = 3'd1,
    ST_R1_ERR    = 3'd2,
    ST_NO_R1     = 3'd3,
    ST_BAD_TOKEN = 3'd4,
    ST_CRC_BAD   = 3'd5,
    ST_TIMEOUT   = 3'd6
  } status_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       block_end;
    logic [7:0] r1_value;
    status_t    status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] block_count;
    logic [15:0] token_timeout;
  } cfg_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/sd_spi_block_read_receiver.sv */
// A word accepted into the input register passes through the state machine to the result register.
// Throughput: one word per cycle unless out_stall holds the pipe; the input and result registers form a two-stage pipe.
// The state machine advances once per word, with a combinational byte-wide CRC update.
// Reset: synchronous active-low rst_n clears the valid flags of both pipe stages and all protocol state;
// block_count returns to 1 and token_timeout to 4096.
`include "sd_spi_block_read_receiver_macros.svh"

module sd_spi_block_read_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sdrd_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sdrd_pkg::out_word_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sdrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);
  import sdrd_pkg::*;

  logic      v1_r, v2_r;
  in_word_t  in_r;
  out_word_t out_r;
  out_word_t res;
  cfg_t      cfg_r;
  logic      adv2, move;

  assign adv2      = !v2_r || !out_stall;
  assign move      = v1_r && adv2;
  assign in_stall  = v1_r && !adv2;
  assign out_valid = v2_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  sdrd_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (move),
    .item  (in_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r                <= 1'b0;
      v2_r                <= 1'b0;
      cfg_r.block_count   <= 16'd1;
      cfg_r.token_timeout <= 16'd4096;
    end else begin
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (!in_stall) begin
        v1_r <= in_valid;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCK_COUNT:   cfg_r.block_count   <= cfg_data;
          CFG_TOKEN_TIMEOUT: cfg_r.token_timeout <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (move) begin
      out_r <= res;
    end
  end

  `SDRD_ASSERT_IMPL(a_payload_is_busy, v2_r && out_r.data_valid, (out_r.status == ST_BUSY) && !out_r.block_end)
  `SDRD_ASSERT_IMPL(a_stall_only_full, in_stall, v1_r && v2_r)
  `SDRD_ASSERT_NEXT(a_move_fills_out, move, v2_r)

endmodule

/* rtl/core/sdrd_fsm.sv */
// Protocol state machine: R1 wait, token hunt, payload with CRC, CRC check.
`include "sd_spi_block_read_receiver_macros.svh"

module sdrd_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sdrd_pkg::in_word_t  item,
  input  sdrd_pkg::cfg_t      cfg,
  output sdrd_pkg::out_word_t res
);
  import sdrd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_R1,
    PH_TOKEN,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_END
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [3:0]     r1_attempts_r, r1_attempts_nxt;
  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [15:0]    blocks_done_r, blocks_done_nxt;
  logic [15:0]    crc_accum_r, crc_accum_nxt;
  logic [7:0]     crc_high_r, crc_high_nxt;
  logic [15:0]    idle_count_r, idle_count_nxt;
  logic [7:0]     r1_reg_r, r1_reg_nxt;
  status_t        final_status_r, final_status_nxt;

  logic [16:0]    idle_inc;
  logic [IDX_W:0] idx_inc;
  logic [15:0]    blocks_inc;

  always_comb begin
    phase_nxt        = phase_r;
    r1_attempts_nxt  = r1_attempts_r;
    byte_index_nxt   = byte_index_r;
    blocks_done_nxt  = blocks_done_r;
    crc_accum_nxt    = crc_accum_r;
    crc_high_nxt     = crc_high_r;
    idle_count_nxt   = idle_count_r;
    r1_reg_nxt       = r1_reg_r;
    final_status_nxt = final_status_r;
    idle_inc         = {1'b0, idle_count_r} + 17'd1;
    idx_inc          = {1'b0, byte_index_r} + (IDX_W+1)'(1);
    blocks_inc       = blocks_done_r + 16'd1;
    res.data_byte    = 8'h00;
    res.data_valid   = 1'b0;
    res.block_end    = 1'b0;

    if (item.op == OP_START) begin
      phase_nxt        = PH_R1;
      r1_attempts_nxt  = 4'd0;
      byte_index_nxt   = '0;
      blocks_done_nxt  = 16'd0;
      crc_accum_nxt    = 16'd0;
      crc_high_nxt     = 8'h00;
      idle_count_nxt   = 16'd0;
      r1_reg_nxt       = IDLE_BYTE;
      final_status_nxt = ST_BUSY;
    end else begin
      case (phase_r)
        PH_R1: begin
          if (item.rx_byte == IDLE_BYTE) begin
            if (r1_attempts_r < 4'(R1_RETRIES)) begin
              r1_attempts_nxt = r1_attempts_r + 4'd1;
            end else begin
              phase_nxt        = PH_END;
              final_status_nxt = ST_NO_R1;
            end
          end else begin
            r1_reg_nxt = item.rx_byte;
            if (item.rx_byte != 8'h00) begin
              phase_nxt        = PH_END;
              final_status_nxt = ST_R1_ERR;
            end else begin
              phase_nxt      = PH_TOKEN;
              idle_count_nxt = 16'd0;
            end
          end
        end
        PH_TOKEN: begin
          if (item.rx_byte == IDLE_BYTE) begin
            if (idle_inc >= {1'b0, cfg.token_timeout}) begin
              phase_nxt        = PH_END;
              final_status_nxt = ST_TIMEOUT;
            end
            idle_count_nxt = idle_inc[15:0];
          end else if (item.rx_byte == DATA_TOKEN) begin
            phase_nxt      = PH_DATA;
            byte_index_nxt = '0;
            crc_accum_nxt  = 16'd0;
          end else begin
            phase_nxt        = PH_END;
            final_status_nxt = ST_BAD_TOKEN;
          end
        end
        PH_DATA: begin
          res.data_byte  = item.rx_byte;
          res.data_valid = 1'b1;
          crc_accum_nxt  = crc_update(crc_accum_r, item.rx_byte);
          if (idx_inc >= (IDX_W+1)'(BLOCK_BYTES)) begin
            byte_index_nxt = '0;
            phase_nxt      = PH_CRC_HI;
          end else begin
            byte_index_nxt = idx_inc[IDX_W-1:0];
          end
        end
        PH_CRC_HI: begin
          crc_high_nxt = item.rx_byte;
          phase_nxt    = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          res.block_end = 1'b1;
          if ({crc_high_r, item.rx_byte} != crc_accum_r) begin
            phase_nxt        = PH_END;
            final_status_nxt = ST_CRC_BAD;
          end else begin
            blocks_done_nxt = blocks_inc;
            if (blocks_inc >= cfg.block_count) begin
              phase_nxt        = PH_END;
              final_status_nxt = ST_DONE;
            end else begin
              phase_nxt      = PH_TOKEN;
              idle_count_nxt = 16'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    res.r1_value = r1_reg_nxt;
    res.status   = (phase_nxt == PH_END) ? final_status_nxt : ST_BUSY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      r1_attempts_r  <= 4'd0;
      byte_index_r   <= '0;
      blocks_done_r  <= 16'd0;
      crc_accum_r    <= 16'd0;
      crc_high_r     <= 8'h00;
      idle_count_r   <= 16'd0;
      r1_reg_r       <= IDLE_BYTE;
      final_status_r <= ST_BUSY;
    end else if (step) begin
      phase_r        <= phase_nxt;
      r1_attempts_r  <= r1_attempts_nxt;
      byte_index_r   <= byte_index_nxt;
      blocks_done_r  <= blocks_done_nxt;
      crc_accum_r    <= crc_accum_nxt;
      crc_high_r     <= crc_high_nxt;
      idle_count_r   <= idle_count_nxt;
      r1_reg_r       <= r1_reg_nxt;
      final_status_r <= final_status_nxt;
    end
  end

  `SDRD_ASSERT_IMPL(a_data_after_good_r1, phase_r == PH_DATA, r1_reg_r == 8'h00)
  `SDRD_ASSERT_IMPL(a_end_has_status, phase_r == PH_END, final_status_r != ST_BUSY)
  `SDRD_ASSERT_IMPL(a_r1_attempts_bound, phase_r == PH_R1, r1_attempts_r <= 4'(R1_RETRIES))

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the SD card SPI-mode block read receiver.
`timescale 1ns / 1ps

module testbench;
  import sdrd_pkg::*;

  localparam int unsigned MAX_CYCLES = 500000;

  typedef enum logic [2:0] {
    RX_IDLE, RX_R1, RX_TOKEN, RX_DATA, RX_CRC_HI, RX_CRC_LO, RX_END
  } rx_phase_t;

  typedef enum int {READ_RANDOM, READ_GOOD, READ_CRC_BAD} read_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BLOCK_COUNT;
  logic [15:0] cfg_data = '0;

  in_word_t miso_queue[$];
  out_word_t predicted_results[$];
  out_word_t want_word;
  int unsigned queued_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;
  int fail_count = 0;
  bit send_hold;

  logic [15:0] cfg_blocks = 16'd1;
  logic [15:0] cfg_timeout = 16'd4096;

  rx_phase_t rx_phase = RX_IDLE;
  logic [3:0] r1_tries = '0;
  int unsigned data_count = 0;
  logic [15:0] good_blocks = '0;
  logic [15:0] crc_run = '0;
  logic [7:0] crc_hi_seen = '0;
  logic [15:0] idle_run = '0;
  logic [7:0] r1_seen = 8'hFF;
  status_t end_status = ST_BUSY;

  sd_spi_block_read_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      if (c[15] ^ b[k]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void stop_read(input status_t s);
    end_status = s;
    rx_phase = RX_END;
  endfunction

  function automatic out_word_t predict_receiver(input in_word_t w);
    out_word_t r;
    logic [16:0] idle_next;
    r = '0;
    if (w.op == OP_START) begin
      rx_phase = RX_R1;
      r1_tries = '0;
      data_count = 0;
      good_blocks = '0;
      crc_run = '0;
      crc_hi_seen = '0;
      idle_run = '0;
      r1_seen = 8'hFF;
      end_status = ST_BUSY;
    end else begin
      case (rx_phase)
        RX_R1: begin
          if (w.rx_byte == IDLE_BYTE) begin
            if (r1_tries < R1_RETRIES) begin
              r1_tries = r1_tries + 4'd1;
            end else begin
              stop_read(ST_NO_R1);
            end
          end else begin
            r1_seen = w.rx_byte;
            if (w.rx_byte != 8'h00) begin
              stop_read(ST_R1_ERR);
            end else begin
              rx_phase = RX_TOKEN;
              idle_run = '0;
            end
          end
        end
        RX_TOKEN: begin
          if (w.rx_byte == IDLE_BYTE) begin
            idle_next = {1'b0, idle_run} + 17'd1;
            if (idle_next >= {1'b0, cfg_timeout}) begin
              stop_read(ST_TIMEOUT);
            end
            idle_run = idle_next[15:0];
          end else if (w.rx_byte == DATA_TOKEN) begin
            rx_phase = RX_DATA;
            data_count = 0;
            crc_run = '0;
          end else begin
            stop_read(ST_BAD_TOKEN);
          end
        end
        RX_DATA: begin
          r.data_byte = w.rx_byte;
          r.data_valid = 1'b1;
          crc_run = crc16_next(crc_run, w.rx_byte);
          data_count++;
          if (data_count >= BLOCK_BYTES) begin
            data_count = 0;
            rx_phase = RX_CRC_HI;
          end
        end
        RX_CRC_HI: begin
          crc_hi_seen = w.rx_byte;
          rx_phase = RX_CRC_LO;
        end
        RX_CRC_LO: begin
          r.block_end = 1'b1;
          if ({crc_hi_seen, w.rx_byte} != crc_run) begin
            stop_read(ST_CRC_BAD);
          end else begin
            good_blocks = good_blocks + 16'd1;
            if (good_blocks >= cfg_blocks) begin
              stop_read(ST_DONE);
            end else begin
              rx_phase = RX_TOKEN;
              idle_run = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    r.r1_value = r1_seen;
    r.status = (rx_phase == RX_END) ? end_status : ST_BUSY;
    return r;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    in_word_t w;
    w.op = OP_BYTE;
    w.rx_byte = b;
    miso_queue.push_back(w);
    queued_count++;
  endtask

  task automatic push_start();
    in_word_t w;
    w.op = OP_START;
    w.rx_byte = 8'($urandom_range(0, 255));
    miso_queue.push_back(w);
    queued_count++;
  endtask

  task automatic push_noise();
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
  endtask

  // One read transfer; random reads stop early at a random point most of the time.
  task automatic queue_read(input logic [15:0] blocks_cfg, input logic [15:0] tmo,
                            input read_kind_t kind);
    int unsigned roll;
    int unsigned nblk;
    int unsigned idle_max;
    int unsigned cut;
    logic [15:0] crc;
    logic [7:0] b;
    push_start();
    roll = (kind == READ_RANDOM) ? $urandom_range(0, 99) : 99;
    if (roll < 6) begin
      repeat (R1_RETRIES + 1) push_byte(IDLE_BYTE);
      push_noise();
      return;
    end
    repeat ($urandom_range(0, R1_RETRIES)) push_byte(IDLE_BYTE);
    if (roll < 14) begin
      push_byte(8'($urandom_range(1, 254)));
      push_noise();
      return;
    end
    push_byte(8'h00);
    nblk = (blocks_cfg == 0) ? 1 : ((blocks_cfg > 2) ? 2 : blocks_cfg);
    idle_max = (tmo == 0) ? 0 : ((tmo - 1 > 6) ? 6 : tmo - 1);
    for (int unsigned blk = 0; blk < nblk; blk++) begin
      roll = (kind == READ_RANDOM) ? $urandom_range(0, 99) : 99;
      if (roll < 8 && tmo <= 64) begin
        repeat ((tmo == 0) ? 1 : tmo) push_byte(IDLE_BYTE);
        push_noise();
        return;
      end
      repeat ($urandom_range(0, idle_max)) push_byte(IDLE_BYTE);
      if (roll < 16) begin
        push_byte(8'($urandom_range(0, 253)));
        push_noise();
        return;
      end
      push_byte(DATA_TOKEN);
      cut = (roll < 90) ? $urandom_range(0, 40) : BLOCK_BYTES;
      crc = '0;
      for (int unsigned i = 0; i < BLOCK_BYTES && i < cut; i++) begin
        b = 8'($urandom_range(0, 255));
        push_byte(b);
        crc = crc16_next(crc, b);
      end
      if (cut < BLOCK_BYTES) begin
        return;
      end
      if ((kind == READ_CRC_BAD && blk == nblk - 1) ||
          (kind == READ_RANDOM && $urandom_range(0, 5) == 0)) begin
        crc = crc ^ 16'(1 << $urandom_range(0, 15));
        push_byte(crc[15:8]);
        push_byte(crc[7:0]);
        push_noise();
        return;
      end
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);
    end
    push_noise();
  endtask

  task automatic drain();
    while (miso_queue.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BLOCK_COUNT) begin
      cfg_blocks = value;
    end else begin
      cfg_timeout = value;
    end
    @(posedge clk);
  endtask

  task automatic fill_random(input int unsigned budget);
    int unsigned first;
    first = queued_count;
    while (queued_count - first < budget) queue_read(cfg_blocks, cfg_timeout, READ_RANDOM);
  endtask

  task automatic run_phase(input logic [15:0] blocks, input logic [15:0] tmo,
                           input read_kind_t kind, input int unsigned budget);
    write_reg(CFG_BLOCK_COUNT, blocks);
    write_reg(CFG_TOKEN_TIMEOUT, tmo);
    if (kind != READ_RANDOM) begin
      queue_read(cfg_blocks, cfg_timeout, kind);
    end
    fill_random(budget);
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      send_hold = in_valid;
      if (in_valid && !in_stall) begin
        predicted_results.push_back(predict_receiver(in_data));
        send_hold = 1'b0;
      end
      if (!send_hold) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (miso_queue.size() > 0) begin
          in_data <= miso_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = draw_wait(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          fail_count++;
        end else begin
          want_word = predicted_results.pop_front();
          if (out_data.data_byte !== want_word.data_byte) begin
            $error("data_byte: expected %0d, got %0d", want_word.data_byte, out_data.data_byte);
            fail_count++;
          end
          if (out_data.data_valid !== want_word.data_valid) begin
            $error("data_valid: expected %0d, got %0d", want_word.data_valid,
                   out_data.data_valid);
            fail_count++;
          end
          if (out_data.block_end !== want_word.block_end) begin
            $error("block_end: expected %0d, got %0d", want_word.block_end, out_data.block_end);
            fail_count++;
          end
          if (out_data.r1_value !== want_word.r1_value) begin
            $error("r1_value: expected %0d, got %0d", want_word.r1_value, out_data.r1_value);
            fail_count++;
          end
          if (out_data.status !== want_word.status) begin
            $error("status: expected %0d, got %0d", want_word.status, out_data.status);
            fail_count++;
          end
        end
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("sd_spi_block_read_receiver verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: stray bytes, R1 handling, token errors and an abandoned block.
    push_byte(8'h00);
    push_byte(IDLE_BYTE);
    push_start();
    push_byte(IDLE_BYTE);
    push_byte(IDLE_BYTE);
    push_byte(8'h00);
    push_start();
    push_byte(8'h80);
    push_byte(DATA_TOKEN);
    push_start();
    repeat (R1_RETRIES + 1) push_byte(IDLE_BYTE);
    push_start();
    push_byte(8'h00);
    push_byte(8'h12);
    push_start();
    push_byte(8'h00);
    push_byte(IDLE_BYTE);
    push_byte(DATA_TOKEN);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_start();
    queue_read(cfg_blocks, cfg_timeout, READ_GOOD);
    fill_random(60);
    drain();

    run_phase(16'd2, 16'd1, READ_CRC_BAD, 40);
    run_phase(16'hFFFF, 16'hFFFF, READ_RANDOM, 40);
    run_phase(16'd0, 16'd0, READ_RANDOM, 40);
    run_phase(16'd1, 16'd3, READ_RANDOM, 40);

    if (fail_count == 0) begin
      $display("sd_spi_block_read_receiver verification clean");
    end else begin
      $display("sd_spi_block_read_receiver verification failed");
    end
    $finish;
  end

endmodule
